>>> rtl/pna_pkg.sv
// port number allocator package: word types, opcodes and status codes
// no dependencies
package pna_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FIND  = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_NONE = 3'd1,
        ST_USED = 3'd2,
        ST_SYS  = 3'd3,
        ST_FULL = 3'd4,
        ST_MISS = 3'd5
    } status_t;

    localparam logic [1:0] REG_DYN_LOW  = 2'd0;
    localparam logic [1:0] REG_DYN_HIGH = 2'd1;
    localparam logic [1:0] REG_USER_LOW = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] port;
        logic [31:0] tag;
        logic        allow_system;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_port;
        logic [31:0] result_tag;
        logic        table_empty;
    } rsp_word_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic [15:0] key;
        logic        wr;
        logic        clr;
        logic [63:0] wr_tag;
    } cell_ctl_t;

endpackage

>>> rtl/pna_req_if.sv
// request channel: valid/ready handshake carrying one request word
// depends on pna_pkg
interface pna_req_if;
    import pna_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pna_rsp_if.sv
// response channel: valid/ready handshake carrying one response word
// depends on pna_pkg
interface pna_rsp_if;
    import pna_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/port_number_allocator.sv
// port number allocator top level: sequencer, config registers, cell row
// depends on pna_pkg, pna_req_if, pna_rsp_if, pna_cell
//
// usage
//   req channel takes one word: op (allocate, find, free), port, tag and
//   allow_system. rsp channel returns exactly one word per request: status,
//   result_port, result_tag and table_empty (after the request took effect).
//   config port: cfg_we writes cfg_data to the register cfg_index
//   (0 dynamic_low, 1 dynamic_high, 2 user_low); write only while idle.
// timing
//   one request at a time. a named allocate, find or free passes from idle
//   through the run and report states; the report state loads the response
//   word into the output register and the next request is taken back in
//   idle. an any-port allocate steps one candidate per cycle through the
//   row of cells, every cell comparing its port in parallel, and stays in
//   the run state while it skips candidates (used ones and candidate 0).
// reset
//   rst_n clears every valid mark at once, so the table is empty; config
//   registers return to 49152, 65535 and 1024.
// stall
//   the response word sits in an output register until taken; a finished
//   request waits in the report state and req.ready stays low meanwhile.
module port_number_allocator #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TAG_BITS      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    pna_req_if.sink     req,
    pna_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pna_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_REPORT = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] dyn_low_reg, dyn_high_reg, user_low_reg;
    req_word_t   cur_reg;
    logic [16:0] cand_reg, cand_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] rport_reg, rport_next;
    logic [31:0] rtag_reg, rtag_next;
    logic        rsp_valid_reg;
    rsp_word_t   rsp_data_reg;

    cell_ctl_t   ctl;
    logic        free_chain [TABLE_ENTRIES+1];
    logic        hit_chain  [TABLE_ENTRIES+1];
    logic        any_chain  [TABLE_ENTRIES+1];
    logic [63:0] tag_chain  [TABLE_ENTRIES+1];
    logic        hit, has_free, any_valid;
    logic [63:0] tag_or;
    logic        any_port;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_low_reg  <= 16'd49152;
            dyn_high_reg <= 16'd65535;
            user_low_reg <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DYN_LOW:  dyn_low_reg  <= cfg_data;
                REG_DYN_HIGH: dyn_high_reg <= cfg_data;
                REG_USER_LOW: user_low_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // row of cells, chained for priority and tag collection
    assign free_chain[0] = 1'b0;
    assign hit_chain[0]  = 1'b0;
    assign any_chain[0]  = 1'b0;
    assign tag_chain[0]  = 64'd0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        pna_cell #(.TAG_BITS(TAG_BITS)) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .free_seen_in  (free_chain[i]),
            .hit_in        (hit_chain[i]),
            .any_valid_in  (any_chain[i]),
            .tag_or_in     (tag_chain[i]),
            .free_seen_out (free_chain[i+1]),
            .hit_out       (hit_chain[i+1]),
            .any_valid_out (any_chain[i+1]),
            .tag_or_out    (tag_chain[i+1])
        );
    end

    assign hit       = hit_chain[TABLE_ENTRIES];
    assign has_free  = free_chain[TABLE_ENTRIES];
    assign any_valid = any_chain[TABLE_ENTRIES];
    assign tag_or    = tag_chain[TABLE_ENTRIES];
    assign any_port  = (cur_reg.port == 16'd0);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        status_next  = status_reg;
        rport_next   = rport_reg;
        rtag_next    = rtag_reg;
        ctl.key      = cand_reg[15:0];
        ctl.wr       = 1'b0;
        ctl.clr      = 1'b0;
        ctl.wr_tag   = 64'(cur_reg.tag);
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_RUN;
                    // any-port search starts at dynamic_low, others key on port
                    if (req.data.op == OP_ALLOC && req.data.port == 16'd0)
                    begin
                        cand_next = {1'b0, dyn_low_reg};
                    end
                    else
                    begin
                        cand_next = {1'b0, req.data.port};
                    end
                end
            end
            S_RUN:
            begin
                rport_next = 16'd0;
                rtag_next  = 32'd0;
                state_next = S_REPORT;
                case (cur_reg.op)
                    OP_ALLOC:
                    begin
                        if (any_port)
                        begin
                            if (cand_reg > {1'b0, dyn_high_reg})
                            begin
                                status_next = ST_NONE;
                            end
                            else if (cand_reg[15:0] != 16'd0 && !hit)
                            begin
                                if (!has_free)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    ctl.wr      = 1'b1;
                                    status_next = ST_OK;
                                    rport_next  = cand_reg[15:0];
                                end
                            end
                            else
                            begin
                                // candidate taken or zero, try the next one
                                cand_next  = cand_reg + 17'd1;
                                state_next = S_RUN;
                            end
                        end
                        else if (!cur_reg.allow_system && cur_reg.port < user_low_reg)
                        begin
                            status_next = ST_SYS;
                        end
                        else if (hit)
                        begin
                            status_next = ST_USED;
                        end
                        else if (!has_free)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.wr      = 1'b1;
                            status_next = ST_OK;
                            rport_next  = cand_reg[15:0];
                        end
                    end
                    OP_FIND:
                    begin
                        status_next = hit ? ST_OK : ST_NONE;
                        rtag_next   = tag_or[31:0];
                    end
                    OP_FREE:
                    begin
                        ctl.clr     = hit;
                        status_next = hit ? ST_OK : ST_MISS;
                    end
                    default:
                    begin
                        status_next = ST_NONE;
                    end
                endcase
            end
            S_REPORT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            cur_reg <= req.data;
        end
        cand_reg   <= cand_next;
        status_reg <= status_next;
        rport_reg  <= rport_next;
        rtag_reg   <= rtag_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == S_REPORT && (!rsp_valid_reg || rsp.ready))
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT && (!rsp_valid_reg || rsp.ready))
        begin
            rsp_data_reg.status      <= status_reg;
            rsp_data_reg.result_port <= rport_reg;
            rsp_data_reg.result_tag  <= rtag_reg;
            rsp_data_reg.table_empty <= !any_valid;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // a cell is never both written and cleared in one cycle
    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr && ctl.clr))
        else $error("write and clear together");

    // the collected tag is zero unless some cell matched
    a_tag_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !hit |-> tag_or == 64'd0)
        else $error("tag without match");

    // a successful allocate leaves the table non-empty
    a_alloc_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == ST_OK
            && rsp_data_reg.result_port != 16'd0) |-> !rsp_data_reg.table_empty)
        else $error("allocate reported empty table");

endmodule

>>> rtl/pna_cell.sv
// one table entry: valid mark, port and tag, with compare and priority chain
// depends on pna_pkg
module pna_cell #(
    parameter int TAG_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pna_pkg::cell_ctl_t ctl,
    input  logic              free_seen_in,
    input  logic              hit_in,
    input  logic              any_valid_in,
    input  logic [63:0]       tag_or_in,
    output logic              free_seen_out,
    output logic              hit_out,
    output logic              any_valid_out,
    output logic [63:0]       tag_or_out
);
    import pna_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [15:0]         port_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                match;
    logic                take;

    assign match = valid_reg && (port_reg == ctl.key);
    // first empty cell along the chain takes the new entry
    assign take  = ctl.wr && !valid_reg && !free_seen_in;

    assign free_seen_out = free_seen_in || !valid_reg;
    assign hit_out       = hit_in || match;
    assign any_valid_out = any_valid_in || valid_reg;
    assign tag_or_out    = tag_or_in | (match ? 64'(tag_reg) : 64'd0);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.clr && match)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            port_reg <= ctl.key;
            tag_reg  <= ctl.wr_tag[TAG_BITS-1:0];
        end
    end

endmodule
